@@ rtl/hid_report_key_event_diff_defines.svh @@
// Assertion macros for the key event differ RTL.
`ifndef HID_REPORT_KEY_EVENT_DIFF_DEFINES_SVH
`define HID_REPORT_KEY_EVENT_DIFF_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define HRKED_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset.
`define HRKED_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HRKED_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define HRKED_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

@@ rtl/hrked_pkg.sv @@
// Types and constants for the HID report key event differ.
package hrked_pkg;

    localparam int SLOTS      = 6;
    localparam int EVENTS     = 2 * SLOTS + 1;
    localparam int EVT_W      = $clog2(EVENTS);
    localparam int EVT_TOGGLE = EVENTS - 1;

    localparam logic [7:0] TOGGLE_MASK_RESET = 8'h04 | 8'h40;
    localparam logic [7:0] KEY_NONE          = 8'h00;

    typedef logic [SLOTS-1:0][7:0] slots_t;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_slot0;
        logic [7:0] key_slot1;
        logic [7:0] key_slot2;
        logic [7:0] key_slot3;
        logic [7:0] key_slot4;
        logic [7:0] key_slot5;
    } hrked_in_t;

    typedef struct packed {
        logic [7:0] event_keycode;
        logic [7:0] event_modifier;
        logic       event_pressed;
        logic       event_last;
    } hrked_out_t;

    // Candidate events of one report, in emission order
    typedef struct packed {
        logic [EVENTS-1:0]       valid;
        logic [EVENTS-1:0][7:0]  code;
        logic [EVENTS-1:0]       pressed;
        logic [7:0]              modifier;
    } hrked_job_t;

endpackage

@@ rtl/hid_report_key_event_diff.sv @@
// Top level of the HID boot keyboard report to key event differ.
//
// Input channel (s_valid/s_ready/s_data): one request per keyboard report,
// a modifier byte plus six rollover keycode slots.
// Output channel (m_valid/m_ready/m_data): key events, presses in slot
// order, then releases in slot order, then at most one modifier toggle;
// event_last marks the final event of a report. A report that changes
// nothing yields no events.
// The first event of a report goes through the job register, then the
// event output register. Events leave at one event per cycle while the
// receiver accepts; a report has at most 13 events, and the limit is the
// single event output register. s_ready rises again in the cycle the last event
// of the held report moves to the output register, so reports run back to
// back with no gap.
// Twelve compare lanes (six press, six release) evaluate a report in the
// accepting cycle; the previous report is updated at the same edge.
// cfg_we/cfg_wdata write the toggle modifier mask, taking effect at the
// next report. Reset (aresetn low, synchronous) clears the previous
// report and modifier, sets the mask to both alt keys, and empties the
// pipeline. A stalled receiver holds the output; s_ready drops once a
// report is waiting behind it.
`include "hid_report_key_event_diff_defines.svh"

module hid_report_key_event_diff
    import hrked_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  hrked_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output hrked_out_t m_data
);

    logic [7:0]       tmask_reg, tmask_next;
    logic [7:0]       prev_mod_reg, prev_mod_next;
    slots_t           prev_keys_reg, prev_keys_next;
    slots_t           new_keys;
    logic [SLOTS-1:0] press_hit, rel_hit;
    logic             accept, was_on, now_on;
    hrked_job_t       job;

    assign new_keys[0] = s_data.key_slot0;
    assign new_keys[1] = s_data.key_slot1;
    assign new_keys[2] = s_data.key_slot2;
    assign new_keys[3] = s_data.key_slot3;
    assign new_keys[4] = s_data.key_slot4;
    assign new_keys[5] = s_data.key_slot5;

    assign accept = s_valid && s_ready;

    // press lanes look for new codes missing from the previous report,
    // release lanes for previous codes missing from the new one
    for (genvar g = 0; g < SLOTS; g++) begin : g_lane
        hrked_lane u_press (
            .code   (new_keys[g]),
            .others (prev_keys_reg),
            .hit    (press_hit[g])
        );
        hrked_lane u_rel (
            .code   (prev_keys_reg[g]),
            .others (new_keys),
            .hit    (rel_hit[g])
        );
    end

    always_comb begin
        was_on = (prev_mod_reg & tmask_reg) != 8'h00;
        now_on = (s_data.modifier_bits & tmask_reg) != 8'h00;
        job.modifier = s_data.modifier_bits;
        for (int i = 0; i < SLOTS; i++) begin
            job.valid[i]           = press_hit[i];
            job.code[i]            = new_keys[i];
            job.pressed[i]         = 1'b1;
            job.valid[SLOTS + i]   = rel_hit[i];
            job.code[SLOTS + i]    = prev_keys_reg[i];
            job.pressed[SLOTS + i] = 1'b0;
        end
        job.valid[EVT_TOGGLE]   = was_on != now_on;
        job.code[EVT_TOGGLE]    = KEY_NONE;
        job.pressed[EVT_TOGGLE] = now_on;
    end

    always_comb begin
        tmask_next     = cfg_we ? cfg_wdata : tmask_reg;
        prev_mod_next  = accept ? s_data.modifier_bits : prev_mod_reg;
        prev_keys_next = accept ? new_keys : prev_keys_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tmask_reg     <= TOGGLE_MASK_RESET;
            prev_mod_reg  <= 8'h00;
            prev_keys_reg <= '0;
        end else begin
            tmask_reg     <= tmask_next;
            prev_mod_reg  <= prev_mod_next;
            prev_keys_reg <= prev_keys_next;
        end
    end

    hrked_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .job_in  (job),
        .take_ok (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a report's events leave without gaps until its last one
    `HRKED_ASSERT_NEXT(a_no_gap, aclk, aresetn, m_valid && m_ready && !m_data.event_last, m_valid, "gap inside one report's events")
    // a zero keycode is only the toggle event, which always closes a report
    `HRKED_ASSERT_IMPL(a_toggle_last, aclk, aresetn, m_valid && (m_data.event_keycode == KEY_NONE), m_data.event_last, "toggle event not last")

endmodule

@@ rtl/hrked_lane.sv @@
// One compare lane: flags a nonzero code that is absent from the other report.
module hrked_lane
    import hrked_pkg::*;
(
    input  logic [7:0] code,
    input  slots_t     others,
    output logic       hit
);

    logic found;

    always_comb begin
        found = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (others[j] == code) begin
                found = 1'b1;
            end
        end
        hit = (code != KEY_NONE) && !found;
    end

endmodule

@@ rtl/hrked_merge.sv @@
// Merge stage: walks the lane flags of one report and emits one event per cycle while the receiver accepts.
module hrked_merge
    import hrked_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  hrked_job_t job_in,
    output logic       take_ok,
    output logic       m_valid,
    input  logic       m_ready,
    output hrked_out_t m_data
);

    logic              job_valid_reg, job_valid_next;
    hrked_job_t        job_reg, job_next;
    logic              m_valid_reg, m_valid_next;
    hrked_out_t        m_data_reg, m_data_next;
    logic [EVT_W-1:0]  sel;
    logic [EVENTS-1:0] rem;
    logic              adv, fire, done;

    always_comb begin
        sel = '0;
        for (int i = EVENTS - 1; i >= 0; i--) begin
            if (job_reg.valid[i]) begin
                sel = EVT_W'(i);
            end
        end
        rem  = job_reg.valid & ~(EVENTS'(1) << sel);
        adv  = !m_valid_reg || m_ready;
        fire = job_valid_reg && adv;
        done = fire && (rem == '0);
        take_ok = !job_valid_reg || done;
    end

    always_comb begin
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        if (fire) begin
            job_next.valid = rem;
            job_valid_next = !done;
            m_valid_next   = 1'b1;
            m_data_next.event_keycode  = job_reg.code[sel];
            m_data_next.event_modifier = job_reg.modifier;
            m_data_next.event_pressed  = job_reg.pressed[sel];
            m_data_next.event_last     = (rem == '0);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            job_next       = job_in;
            job_valid_next = |job_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        job_reg    <= job_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
